@@ src/mme_pkg.sv @@
// ----------------------------------------------------------------------------
// mme_pkg
// Types and constants shared by the matrix multiply engine modules.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int ELEM_W = 16;   // Q8.8 operand width
    localparam int SUM_W  = 40;   // Q24.16 result width
    localparam int IDX_W  = 3;    // row / column index width on the ports
    localparam int SIZE_W = 4;    // size register width
    localparam int OP_W   = 2;
    localparam int CFG_W  = 2;

    localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

    localparam logic [CFG_W-1:0] CFG_LEFT_ROWS  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_W-1:0] CFG_RIGHT_COLS = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [ELEM_W-1:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] product_sum;
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic                    last_of_run;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic                     wr_left;
        logic                     wr_right;
        logic [IDX_W-1:0]         wr_row;
        logic [IDX_W-1:0]         wr_col;
        logic signed [ELEM_W-1:0] wr_data;
        logic                     mac_valid;
        logic                     mac_first;
        logic                     mac_last;
        logic                     mac_zero;     // empty inner dimension
        logic                     mac_run_last;
        logic [IDX_W-1:0]         mac_row;
        logic [IDX_W-1:0]         mac_col;
        logic [IDX_W-1:0]         mac_k;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic advance;
    } status_t;

endpackage

@@ src/mme_ctrl.sv @@
// ----------------------------------------------------------------------------
// mme_ctrl
// Size registers, item acceptance and the row / column / inner loop sequencer.
// ----------------------------------------------------------------------------
module mme_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mme_pkg::in_item_t             s_data,
    input  logic                          cfg_valid,
    input  logic [mme_pkg::CFG_W-1:0]     cfg_index,
    input  logic [mme_pkg::SIZE_W-1:0]    cfg_data,
    output mme_pkg::cmd_t                 cmd,
    input  mme_pkg::status_t              status
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam logic [mme_pkg::SIZE_W-1:0] DIM_MAX = mme_pkg::SIZE_W'(MAX_DIM);

    logic                        state_reg, state_next;
    logic [mme_pkg::SIZE_W-1:0]  left_rows_reg, inner_size_reg, right_cols_reg;
    logic [mme_pkg::IDX_W-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [mme_pkg::SIZE_W-1:0]  nr, nk, nc;
    logic [mme_pkg::SIZE_W-1:0]  row_w, col_w, i_inc, j_inc, k_inc;
    logic                        in_xfer;

    assign nr = (left_rows_reg  > DIM_MAX) ? DIM_MAX : left_rows_reg;
    assign nk = (inner_size_reg > DIM_MAX) ? DIM_MAX : inner_size_reg;
    assign nc = (right_cols_reg > DIM_MAX) ? DIM_MAX : right_cols_reg;

    assign row_w = {1'b0, s_data.row_index};
    assign col_w = {1'b0, s_data.col_index};
    assign i_inc = {1'b0, i_reg} + 4'd1;
    assign j_inc = {1'b0, j_reg} + 4'd1;
    assign k_inc = {1'b0, k_reg} + 4'd1;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_xfer = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_rows_reg  <= mme_pkg::SIZE_RESET;
            inner_size_reg <= mme_pkg::SIZE_RESET;
            right_cols_reg <= mme_pkg::SIZE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                mme_pkg::CFG_LEFT_ROWS:  left_rows_reg  <= cfg_data;
                mme_pkg::CFG_INNER_SIZE: inner_size_reg <= cfg_data;
                mme_pkg::CFG_RIGHT_COLS: right_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;

        cmd              = '0;
        cmd.wr_row       = s_data.row_index;
        cmd.wr_col       = s_data.col_index;
        cmd.wr_data      = s_data.element_value;
        cmd.mac_row      = i_reg;
        cmd.mac_col      = j_reg;
        cmd.mac_k        = k_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (s_data.operation)
                        mme_pkg::OP_LOAD_LEFT:
                            cmd.wr_left = (row_w < nr) && (col_w < nk);
                        mme_pkg::OP_LOAD_RIGHT:
                            cmd.wr_right = (row_w < nk) && (col_w < nc);
                        mme_pkg::OP_COMPUTE: begin
                            if (nr != '0 && nc != '0) begin
                                state_next = ST_RUN;
                                i_next     = '0;
                                j_next     = '0;
                                k_next     = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                cmd.mac_valid    = 1'b1;
                cmd.mac_first    = (k_reg == '0);
                cmd.mac_zero     = (nk == '0);
                cmd.mac_last     = (nk == '0) || (k_inc == nk);
                cmd.mac_run_last = cmd.mac_last && (i_inc == nr) && (j_inc == nc);
                if (status.advance) begin
                    if (!cmd.mac_last) begin
                        k_next = k_reg + 3'd1;
                    end else begin
                        k_next = '0;
                        if (j_inc == nc) begin
                            j_next = '0;
                            i_next = i_reg + 3'd1;
                        end else begin
                            j_next = j_reg + 3'd1;
                        end
                        if (cmd.mac_run_last) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

@@ src/mme_datapath.sv @@
// ----------------------------------------------------------------------------
// mme_datapath
// Operand stores, multiplier, saturating accumulator and result register.
// ----------------------------------------------------------------------------
module mme_datapath #(
    parameter int MAX_DIM = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mme_pkg::cmd_t       cmd,
    output mme_pkg::status_t    status,
    output logic                m_valid,
    input  logic                m_ready,
    output mme_pkg::out_item_t  m_data
);

    localparam int RW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int EW   = mme_pkg::ELEM_W;
    localparam int PW   = 2 * mme_pkg::ELEM_W;
    localparam int SW   = mme_pkg::SUM_W;
    localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic                      valid;
        logic                      first;
        logic                      last;
        logic                      zero;
        logic                      run_last;
        logic [mme_pkg::IDX_W-1:0] row;
        logic [mme_pkg::IDX_W-1:0] col;
    } tag_t;

    logic signed [EW-1:0] left_mem  [MAX_DIM][MAX_DIM];
    logic signed [EW-1:0] right_mem [MAX_DIM][MAX_DIM];

    logic signed [EW-1:0] left_rd_reg, right_rd_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] acc_reg, acc_next, acc_base;
    logic signed [SW:0]   sum;
    tag_t                 tag1_reg, tag2_reg, tag_in;
    mme_pkg::out_item_t   out_reg;
    logic                 out_valid_reg;
    logic                 adv;

    // whole pipeline holds while a finished result waits
    assign adv            = !out_valid_reg || m_ready;
    assign status.advance = adv;

    assign tag_in = '{valid:    cmd.mac_valid,
                      first:    cmd.mac_first,
                      last:     cmd.mac_last,
                      zero:     cmd.mac_zero,
                      run_last: cmd.mac_run_last,
                      row:      cmd.mac_row,
                      col:      cmd.mac_col};

    always_ff @(posedge aclk) begin
        if (cmd.wr_left) begin
            left_mem[cmd.wr_row[RW-1:0]][cmd.wr_col[RW-1:0]] <= cmd.wr_data;
        end
        if (cmd.wr_right) begin
            right_mem[cmd.wr_row[RW-1:0]][cmd.wr_col[RW-1:0]] <= cmd.wr_data;
        end
        if (adv) begin
            left_rd_reg  <= left_mem[cmd.mac_row[RW-1:0]][cmd.mac_k[RW-1:0]];
            right_rd_reg <= right_mem[cmd.mac_k[RW-1:0]][cmd.mac_col[RW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (tag1_reg.zero) begin
                prod_reg <= '0;
            end else begin
                prod_reg <= left_rd_reg * right_rd_reg;
            end
        end
    end

    assign acc_base = tag2_reg.first ? '0 : acc_reg;
    assign sum      = {acc_base[SW-1], acc_base}
                    + {{(SW+1-PW){prod_reg[PW-1]}}, prod_reg};

    always_comb begin
        if (sum[SW] != sum[SW-1]) begin
            acc_next = sum[SW] ? SUM_MIN : SUM_MAX;
        end else begin
            acc_next = sum[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            tag1_reg      <= tag_in;
            tag2_reg      <= tag1_reg;
            out_valid_reg <= tag2_reg.valid && tag2_reg.last;
            if (tag2_reg.valid) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tag2_reg.valid && tag2_reg.last) begin
            out_reg.product_sum <= acc_next;
            out_reg.out_row     <= tag2_reg.row;
            out_reg.out_col     <= tag2_reg.col;
            out_reg.last_of_run <= tag2_reg.run_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ src/matrix_multiply_engine.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// A compute item runs one multiply-accumulate per cycle through the shared
// multiplier while no finished result waits on m_ready; the next item is taken
// after the run.
// Reset (aresetn, synchronous) sets all sizes to 8; stores hold until written.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
    parameter int MAX_DIM = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mme_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mme_pkg::out_item_t          m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mme_pkg::CFG_W-1:0]   cfg_index,
    input  logic [mme_pkg::SIZE_W-1:0]  cfg_data
);

    mme_pkg::cmd_t    cmd;
    mme_pkg::status_t status;

    assign cfg_ready = 1'b1;

    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    mme_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
